### hdl/xcfp_pkg.sv
// Shared types and constants for the XOR checked frame parser.
// Holds the parse phase enum, the result record and the status codes.
// No dependencies; every other file of the block imports this package.
package xcfp_pkg;

    localparam int DataWidth = 8;
    localparam int CmdWidth  = 16;
    localparam int StatWidth = 3;
    localparam int AddrWidth = 3;
    localparam int BusWidth  = 32;

    localparam logic [DataWidth-1:0] HEAD0_BYTE = 8'hFF;
    localparam logic [DataWidth-1:0] HEAD1_BYTE = 8'h22;
    localparam logic [DataWidth-1:0] LEN_MIN    = 8'h03;
    localparam logic [DataWidth-1:0] TAIL0_BYTE = 8'h0D;
    localparam logic [DataWidth-1:0] TAIL1_BYTE = 8'h0A;
    localparam logic [DataWidth-1:0] ZERO_BYTE  = 8'h00;

    localparam logic [DataWidth-1:0] MAX_LENGTH_RESET = 8'd122;

    // Register index of max_length on the configuration port.
    localparam logic [AddrWidth-3:0] REG_MAX_LENGTH = 1'b0;

    localparam logic [StatWidth-1:0] STATUS_OK       = 3'd0;
    localparam logic [StatWidth-1:0] STATUS_HEAD1    = 3'd1;
    localparam logic [StatWidth-1:0] STATUS_LENGTH   = 3'd2;
    localparam logic [StatWidth-1:0] STATUS_TAIL     = 3'd3;
    localparam logic [StatWidth-1:0] STATUS_CMD_ZERO = 3'd4;
    localparam logic [StatWidth-1:0] STATUS_BRD_ZERO = 3'd5;
    localparam logic [StatWidth-1:0] STATUS_XOR      = 3'd6;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_HEAD1   = 4'd1,
        PH_LEN     = 4'd2,
        PH_CMDH    = 4'd3,
        PH_CMDL    = 4'd4,
        PH_BOARD   = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_XOR     = 4'd7,
        PH_TAIL0   = 4'd8,
        PH_TAIL1   = 4'd9
    } phase_t;

    typedef struct packed {
        logic                 kind;
        logic [DataWidth-1:0] payload_byte;
        logic [StatWidth-1:0] status;
        logic [CmdWidth-1:0]  cmd_id;
        logic [DataWidth-1:0] board_code;
        logic [DataWidth-1:0] payload_length;
    } result_t;

endpackage

### hdl/xcfp_regs.sv
// Configuration register file of the frame parser: the max_length register.
// APB-style slave with pready tied high; depends on xcfp_pkg.
module xcfp_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [xcfp_pkg::AddrWidth-1:0] paddr,
    input  logic [xcfp_pkg::BusWidth-1:0]  pwdata,
    output logic [xcfp_pkg::BusWidth-1:0]  prdata,
    output logic                           pready,
    output logic [xcfp_pkg::DataWidth-1:0] max_length
);
    import xcfp_pkg::*;

    logic [DataWidth-1:0]   max_length_reg;
    logic [AddrWidth-3:0]   reg_index;
    logic                   wr_en;

    // Registers sit on 32-bit words, so the low two address bits are ignored.
    assign reg_index = paddr[AddrWidth-1:2];
    assign wr_en     = psel && penable && pwrite && (reg_index == REG_MAX_LENGTH);
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (wr_en)
        begin
            max_length_reg <= pwdata[DataWidth-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_MAX_LENGTH)
        begin
            prdata = {{(BusWidth-DataWidth){1'b0}}, max_length_reg};
        end
    end

    assign max_length = max_length_reg;

endmodule

### hdl/xcfp_parser.sv
// Frame parser core: input byte register, parse state and next-state logic.
// Produces at most one result per byte; depends on xcfp_pkg.
module xcfp_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rx_valid,
    input  logic [xcfp_pkg::DataWidth-1:0] rx_byte,
    output logic                           rx_stall,
    input  logic [xcfp_pkg::DataWidth-1:0] max_length,
    input  logic                           sink_free,
    output logic                           res_fire,
    output xcfp_pkg::result_t              res
);
    import xcfp_pkg::*;

    logic                 byte_valid_reg;
    logic [DataWidth-1:0] byte_reg;
    logic                 advance;
    logic                 rx_take;

    phase_t               phase_reg, phase_next;
    logic [DataWidth-1:0] frame_length_reg, frame_length_next;
    logic [DataWidth-1:0] byte_count_reg, byte_count_next;
    logic [DataWidth-1:0] running_xor_reg, running_xor_next;
    logic [CmdWidth-1:0]  command_reg, command_next;
    logic [DataWidth-1:0] board_reg, board_next;
    logic                 command_bad_reg, command_bad_next;
    logic                 xor_bad_reg, xor_bad_next;
    logic                 tail_bad_reg, tail_bad_next;

    logic                 tail_bad_final;
    logic [StatWidth-1:0] end_status;
    logic [DataWidth-1:0] b;

    // The held byte is processed whenever the result register can take it.
    assign advance  = byte_valid_reg && sink_free;
    assign rx_stall = byte_valid_reg && !sink_free;
    assign rx_take  = rx_valid && !rx_stall;
    assign b        = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (rx_take || advance)
        begin
            byte_valid_reg <= rx_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            frame_length_reg <= '0;
            byte_count_reg   <= '0;
            running_xor_reg  <= '0;
            command_reg      <= '0;
            board_reg        <= '0;
            command_bad_reg  <= 1'b0;
            xor_bad_reg      <= 1'b0;
            tail_bad_reg     <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            byte_count_reg   <= byte_count_next;
            running_xor_reg  <= running_xor_next;
            command_reg      <= command_next;
            board_reg        <= board_next;
            command_bad_reg  <= command_bad_next;
            xor_bad_reg      <= xor_bad_next;
            tail_bad_reg     <= tail_bad_next;
        end
    end

    // End-of-frame status: tail, then command, board and checksum errors win in that order.
    assign tail_bad_final = tail_bad_reg || (b != TAIL1_BYTE);

    always_comb
    begin
        if (tail_bad_final)
        begin
            end_status = STATUS_TAIL;
        end
        else if (command_bad_reg)
        begin
            end_status = STATUS_CMD_ZERO;
        end
        else if (board_reg == ZERO_BYTE)
        begin
            end_status = STATUS_BRD_ZERO;
        end
        else if (xor_bad_reg)
        begin
            end_status = STATUS_XOR;
        end
        else
        begin
            end_status = STATUS_OK;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        byte_count_next   = byte_count_reg;
        running_xor_next  = running_xor_reg;
        command_next      = command_reg;
        board_next        = board_reg;
        command_bad_next  = command_bad_reg;
        xor_bad_next      = xor_bad_reg;
        tail_bad_next     = tail_bad_reg;
        res_fire          = 1'b0;
        res               = '0;

        case (phase_reg)
            PH_HUNT:
            begin
                if (b == HEAD0_BYTE)
                begin
                    phase_next       = PH_HEAD1;
                    running_xor_next = HEAD0_BYTE;
                end
            end
            PH_HEAD1:
            begin
                if (b == HEAD1_BYTE)
                begin
                    running_xor_next = running_xor_reg ^ b;
                    phase_next       = PH_LEN;
                end
                else
                begin
                    res_fire    = advance;
                    res.kind    = KIND_STATUS;
                    res.status  = STATUS_HEAD1;
                    // The breaking byte may itself start a new frame.
                    if (b == HEAD0_BYTE)
                    begin
                        phase_next       = PH_HEAD1;
                        running_xor_next = HEAD0_BYTE;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            end
            PH_LEN:
            begin
                if ((b < LEN_MIN) || (b > max_length))
                begin
                    res_fire   = advance;
                    res.kind   = KIND_STATUS;
                    res.status = STATUS_LENGTH;
                    if (b == HEAD0_BYTE)
                    begin
                        phase_next       = PH_HEAD1;
                        running_xor_next = HEAD0_BYTE;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                else
                begin
                    frame_length_next = b;
                    running_xor_next  = running_xor_reg ^ b;
                    phase_next        = PH_CMDH;
                end
            end
            PH_CMDH:
            begin
                command_next     = {b, ZERO_BYTE};
                command_bad_next = (b == ZERO_BYTE);
                running_xor_next = running_xor_reg ^ b;
                phase_next       = PH_CMDL;
            end
            PH_CMDL:
            begin
                command_next     = {command_reg[CmdWidth-1:DataWidth], b};
                command_bad_next = command_bad_reg || (b == ZERO_BYTE);
                running_xor_next = running_xor_reg ^ b;
                phase_next       = PH_BOARD;
            end
            PH_BOARD:
            begin
                board_next       = b;
                running_xor_next = running_xor_reg ^ b;
                byte_count_next  = frame_length_reg - LEN_MIN;
                phase_next       = (frame_length_reg != LEN_MIN) ? PH_PAYLOAD : PH_XOR;
            end
            PH_PAYLOAD:
            begin
                running_xor_next = running_xor_reg ^ b;
                res_fire         = advance;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = b;
                byte_count_next  = byte_count_reg - 8'd1;
                if (byte_count_reg == 8'd1)
                begin
                    phase_next = PH_XOR;
                end
            end
            PH_XOR:
            begin
                xor_bad_next = (b != running_xor_reg);
                phase_next   = PH_TAIL0;
            end
            PH_TAIL0:
            begin
                tail_bad_next = (b != TAIL0_BYTE);
                phase_next    = PH_TAIL1;
            end
            PH_TAIL1:
            begin
                tail_bad_next      = tail_bad_final;
                res_fire           = advance;
                res.kind           = KIND_STATUS;
                res.status         = end_status;
                res.cmd_id         = command_reg;
                res.board_code     = board_reg;
                res.payload_length = (end_status == STATUS_OK) ? frame_length_reg : ZERO_BYTE;
                phase_next         = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

endmodule

### hdl/xor_checked_frame_parser.sv
// Top level of the XOR checked frame parser: config registers, parser core
// and the result register. Depends on xcfp_pkg, xcfp_regs and xcfp_parser.
//
// Usage: received bytes enter on the rx channel (rx_valid, rx_stall, rx_byte),
// one transfer per byte. Results leave on the res channel (res_valid,
// res_stall and the result fields). A payload byte of a frame gives a result
// of kind 0; the last byte of a frame gives a status result of kind 1 with the
// command and board; a byte that breaks the second header byte or the length
// byte gives a status result with them zero. Bytes outside a frame give no result.
// Timing: a byte taken from rx sits in the input register and is parsed
// once the result register can take it, which loads its result into the result
// register. The result is presented on res from that register. Throughput is
// one byte per cycle while the receiver does not stall, set by the single
// registered parse step between the two registers.
// When the receiver stalls, the result register holds its contents and the
// input register fills; rx_stall then rises until the result is taken.
// Reset clears both registers, returns the parser to the hunt for FF and sets
// max_length to 122. max_length is written over the APB-style port at byte
// address 0 and should only change while no bytes are in flight.
module xor_checked_frame_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [xcfp_pkg::AddrWidth-1:0] paddr,
    input  logic [xcfp_pkg::BusWidth-1:0]  pwdata,
    output logic [xcfp_pkg::BusWidth-1:0]  prdata,
    output logic                           pready,
    input  logic                           rx_valid,
    output logic                           rx_stall,
    input  logic [xcfp_pkg::DataWidth-1:0] rx_byte,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic                           kind,
    output logic [xcfp_pkg::DataWidth-1:0] payload_byte,
    output logic [xcfp_pkg::StatWidth-1:0] status,
    output logic [xcfp_pkg::CmdWidth-1:0]  cmd_id,
    output logic [xcfp_pkg::DataWidth-1:0] board_code,
    output logic [xcfp_pkg::DataWidth-1:0] payload_length
);
    import xcfp_pkg::*;

    logic [DataWidth-1:0] max_length;
    logic                 sink_free;
    logic                 res_fire;
    result_t              res;
    logic                 res_valid_reg;
    result_t              res_reg;

    xcfp_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .max_length (max_length)
    );

    // The result register can take a new result when it is empty or drains.
    assign sink_free = !res_valid_reg || !res_stall;

    xcfp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_byte    (rx_byte),
        .rx_stall   (rx_stall),
        .max_length (max_length),
        .sink_free  (sink_free),
        .res_fire   (res_fire),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (sink_free)
        begin
            res_valid_reg <= res_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            res_reg <= res;
        end
    end

    assign res_valid      = res_valid_reg;
    assign kind           = res_reg.kind;
    assign payload_byte   = res_reg.payload_byte;
    assign status         = res_reg.status;
    assign cmd_id         = res_reg.cmd_id;
    assign board_code     = res_reg.board_code;
    assign payload_length = res_reg.payload_length;

endmodule

### sim/xcfp_check_pkg.sv
// Frame tracker for the XOR checked frame parser testbench: it follows the byte stream,
// predicts the payload and status transfers that the parser must give and checks them.
// Depends on xcfp_pkg for the phase enum, the result record and the status codes.
package xcfp_check_pkg;

    import xcfp_pkg::*;

    class frame_tracker;

        logic [DataWidth-1:0] max_length;
        phase_t               phase;
        logic [DataWidth-1:0] frame_length;
        logic [DataWidth-1:0] bytes_left;
        logic [DataWidth-1:0] running_xor;
        logic [CmdWidth-1:0]  command;
        logic [DataWidth-1:0] board_byte;
        bit                   command_bad;
        bit                   xor_bad;
        bit                   tail_bad;
        result_t              awaited[$];
        int unsigned          failures;
        int unsigned          results_seen;

        function new();
            max_length   = MAX_LENGTH_RESET;
            phase        = PH_HUNT;
            frame_length = '0;
            bytes_left   = '0;
            running_xor  = '0;
            command      = '0;
            board_byte   = '0;
            command_bad  = 1'b0;
            xor_bad      = 1'b0;
            tail_bad     = 1'b0;
            failures     = 0;
            results_seen = 0;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10)
            begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
        endfunction

        function bit drained();
            return awaited.size() == 0;
        endfunction

        function void push_status(logic [StatWidth-1:0] st, logic [CmdWidth-1:0] cmd,
                                  logic [DataWidth-1:0] brd, logic [DataWidth-1:0] len);
            result_t exp;
            exp                = '0;
            exp.kind           = KIND_STATUS;
            exp.status         = st;
            exp.cmd_id         = cmd;
            exp.board_code     = brd;
            exp.payload_length = len;
            awaited.push_back(exp);
        endfunction

        // A byte that broke the header or the length may itself open a new frame.
        function void rehunt(logic [DataWidth-1:0] b);
            if (b == HEAD0_BYTE)
            begin
                phase       = PH_HEAD1;
                running_xor = HEAD0_BYTE;
            end
            else
            begin
                phase = PH_HUNT;
            end
        endfunction

        function void take_rx_byte(logic [DataWidth-1:0] b);
            result_t              exp;
            logic [StatWidth-1:0] st;
            exp = '0;
            case (phase)
                PH_HUNT:
                begin
                    if (b == HEAD0_BYTE)
                    begin
                        phase       = PH_HEAD1;
                        running_xor = HEAD0_BYTE;
                    end
                end
                PH_HEAD1:
                begin
                    if (b == HEAD1_BYTE)
                    begin
                        running_xor ^= b;
                        phase = PH_LEN;
                    end
                    else
                    begin
                        push_status(STATUS_HEAD1, '0, '0, '0);
                        rehunt(b);
                    end
                end
                PH_LEN:
                begin
                    if (b < LEN_MIN || b > max_length)
                    begin
                        push_status(STATUS_LENGTH, '0, '0, '0);
                        rehunt(b);
                    end
                    else
                    begin
                        frame_length = b;
                        running_xor ^= b;
                        phase = PH_CMDH;
                    end
                end
                PH_CMDH:
                begin
                    command     = {b, ZERO_BYTE};
                    command_bad = (b == ZERO_BYTE);
                    running_xor ^= b;
                    phase = PH_CMDL;
                end
                PH_CMDL:
                begin
                    command[DataWidth-1:0] = b;
                    if (b == ZERO_BYTE)
                    begin
                        command_bad = 1'b1;
                    end
                    running_xor ^= b;
                    phase = PH_BOARD;
                end
                PH_BOARD:
                begin
                    board_byte = b;
                    running_xor ^= b;
                    bytes_left = frame_length - LEN_MIN;
                    phase      = (bytes_left != 0) ? PH_PAYLOAD : PH_XOR;
                end
                PH_PAYLOAD:
                begin
                    running_xor ^= b;
                    exp.kind         = KIND_PAYLOAD;
                    exp.payload_byte = b;
                    awaited.push_back(exp);
                    bytes_left--;
                    if (bytes_left == 0)
                    begin
                        phase = PH_XOR;
                    end
                end
                PH_XOR:
                begin
                    xor_bad = (b != running_xor);
                    phase   = PH_TAIL0;
                end
                PH_TAIL0:
                begin
                    tail_bad = (b != TAIL0_BYTE);
                    phase    = PH_TAIL1;
                end
                PH_TAIL1:
                begin
                    if (b != TAIL1_BYTE)
                    begin
                        tail_bad = 1'b1;
                    end
                    // The first error wins: tail, command, board, then checksum.
                    if (tail_bad)
                        st = STATUS_TAIL;
                    else if (command_bad)
                        st = STATUS_CMD_ZERO;
                    else if (board_byte == ZERO_BYTE)
                        st = STATUS_BRD_ZERO;
                    else if (xor_bad)
                        st = STATUS_XOR;
                    else
                        st = STATUS_OK;
                    push_status(st, command, board_byte,
                                (st == STATUS_OK) ? frame_length : ZERO_BYTE);
                    phase = PH_HUNT;
                end
                default:
                begin
                    phase = PH_HUNT;
                end
            endcase
        endfunction

        function void check_result(result_t got);
            result_t exp;
            results_seen++;
            if (awaited.size() == 0)
            begin
                note_failure($sformatf("result %0d arrived with none expected (kind %0d)",
                                       results_seen, got.kind));
                return;
            end
            exp = awaited.pop_front();
            if (got.kind !== exp.kind)
                note_failure($sformatf("result %0d kind: expected %0d, got %0d",
                                       results_seen, exp.kind, got.kind));
            if (got.payload_byte !== exp.payload_byte)
                note_failure($sformatf("result %0d payload_byte: expected %02h, got %02h",
                                       results_seen, exp.payload_byte, got.payload_byte));
            if (got.status !== exp.status)
                note_failure($sformatf("result %0d status: expected %0d, got %0d",
                                       results_seen, exp.status, got.status));
            if (got.cmd_id !== exp.cmd_id)
                note_failure($sformatf("result %0d cmd_id: expected %04h, got %04h",
                                       results_seen, exp.cmd_id, got.cmd_id));
            if (got.board_code !== exp.board_code)
                note_failure($sformatf("result %0d board_code: expected %02h, got %02h",
                                       results_seen, exp.board_code, got.board_code));
            if (got.payload_length !== exp.payload_length)
                note_failure($sformatf("result %0d payload_length: expected %0d, got %0d",
                                       results_seen, exp.payload_length,
                                       got.payload_length));
        endfunction

    endclass

endpackage

### sim/xor_checked_frame_parser_test.sv
// Self-checking testbench for xor_checked_frame_parser: directed frames, then random
// frames with flaws under several max_length settings and random idling on both sides.
// Depends on xcfp_pkg and on the frame tracker class in xcfp_check_pkg.
module xor_checked_frame_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    import xcfp_pkg::*;
    import xcfp_check_pkg::*;

    // Generous bound on the whole run; the slowest correct run needs far fewer cycles.
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam logic [AddrWidth-1:0] MAX_LENGTH_ADDR = {REG_MAX_LENGTH, 2'b00};

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [AddrWidth-1:0] paddr     = '0;
    logic [BusWidth-1:0]  pwdata    = '0;
    logic [BusWidth-1:0]  prdata;
    logic                 pready;
    logic                 rx_valid  = 1'b0;
    logic                 rx_stall;
    logic [DataWidth-1:0] rx_byte   = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic                 kind;
    logic [DataWidth-1:0] payload_byte;
    logic [StatWidth-1:0] status;
    logic [CmdWidth-1:0]  cmd_id;
    logic [DataWidth-1:0] board_code;
    logic [DataWidth-1:0] payload_length;

    frame_tracker         tracker;
    logic [DataWidth-1:0] outgoing[$];   // bytes waiting to be sent to the parser
    bit                   steady = 1'b0; // while set, neither side idles
    int unsigned          cycle_count = 0;
    int unsigned          stall_hold = 0;

    xor_checked_frame_parser uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .rx_valid       (rx_valid),
        .rx_stall       (rx_stall),
        .rx_byte        (rx_byte),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .status         (status),
        .cmd_id         (cmd_id),
        .board_code     (board_code),
        .payload_length (payload_length)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The run is bounded by a plain cycle counter.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[xor_checked_frame_parser] ERROR");
            $finish;
        end
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    // The result side alternates between runs of taking and runs of stalling. The
    // stall is chosen without looking at res_valid, so stalls land on every phase.
    always @(posedge clk)
    begin
        if (steady)
        begin
            res_stall  <= 1'b0;
            stall_hold = 0;
        end
        else if (stall_hold > 0)
        begin
            stall_hold--;
        end
        else
        begin
            res_stall  <= ($urandom_range(0, 2) == 0);
            stall_hold = pick_gap();
        end
    end

    // Both channels are sampled at the clock edge, before any update of that edge
    // lands. A result transfer is checked before the byte transfer of the same edge is
    // noted, so a stray result can never pair with an expectation made that edge.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                got.kind           = kind;
                got.payload_byte   = payload_byte;
                got.status         = status;
                got.cmd_id         = cmd_id;
                got.board_code     = board_code;
                got.payload_length = payload_length;
                tracker.check_result(got);
            end
            if (rx_valid && !rx_stall)
            begin
                tracker.take_rx_byte(rx_byte);
            end
        end
    end

    // One APB transfer: a setup phase, then an access phase held until pready. Idling
    // with psel low follows, so back-to-back calls never drive psel twice in one step.
    task automatic apb_transfer(input bit wr, input logic [BusWidth-1:0] wdata,
                                output logic [BusWidth-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MAX_LENGTH_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Reads max_length back and compares it with the tracker's copy.
    task automatic check_max_length();
        logic [BusWidth-1:0] rd;
        apb_transfer(1'b0, '0, rd);
        if (rd !== BusWidth'(tracker.max_length))
        begin
            tracker.note_failure($sformatf("max_length readback: expected %0d, got %0d",
                                           tracker.max_length, rd));
        end
    endtask

    task automatic write_max_length(input logic [DataWidth-1:0] value);
        logic [BusWidth-1:0] unused_rd;
        apb_transfer(1'b1, BusWidth'(value), unused_rd);
        tracker.max_length = value;
        check_max_length();
    endtask

    // Offers one byte and holds it until the parser takes it, then maybe idles.
    task automatic send_byte(input logic [DataWidth-1:0] b);
        int unsigned gap;
        rx_byte  <= b;
        rx_valid <= 1'b1;
        do @(posedge clk); while (rx_stall);
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_queued();
        while (outgoing.size() > 0)
        begin
            send_byte(outgoing.pop_front());
        end
    endtask

    // Stops sending and waits until every expected result has come. A byte that makes
    // no result can still be inside the parser then, so the task keeps clocking
    // before it returns, to let such a byte through.
    task automatic settle();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (!tracker.drained())
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Appends the checksum of the frame that starts at index first, then the tail.
    function automatic void close_frame(input int unsigned first);
        logic [DataWidth-1:0] x;
        x = '0;
        for (int unsigned i = first; i < outgoing.size(); i++)
        begin
            x ^= outgoing[i];
        end
        outgoing.push_back(x);
        outgoing.push_back(TAIL0_BYTE);
        outgoing.push_back(TAIL1_BYTE);
    endfunction

    // Short hand-written stream: a good frame with no payload, a bad second header
    // byte that is itself FF, a length of zero, a length above max_length that is FF
    // and so restarts the hunt, and a frame that breaks tail, command and board at once.
    task automatic run_directed();
        int unsigned first;
        outgoing = {8'h00, HEAD0_BYTE, HEAD1_BYTE, LEN_MIN, 8'h01, 8'h02, 8'h03};
        close_frame(1);
        outgoing.push_back(HEAD0_BYTE);
        outgoing.push_back(HEAD0_BYTE);
        outgoing.push_back(HEAD1_BYTE);
        outgoing.push_back(ZERO_BYTE);
        outgoing.push_back(HEAD0_BYTE);
        outgoing.push_back(HEAD1_BYTE);
        outgoing.push_back(8'hFF);
        outgoing.push_back(8'h5A);
        first = outgoing.size();
        outgoing.push_back(HEAD0_BYTE);
        outgoing.push_back(HEAD1_BYTE);
        outgoing.push_back(8'h04);
        outgoing.push_back(ZERO_BYTE);
        outgoing.push_back(ZERO_BYTE);
        outgoing.push_back(ZERO_BYTE);
        outgoing.push_back(8'hFF);
        close_frame(first);
        outgoing[outgoing.size() - 1] = 8'h0B;
        send_queued();
    endtask

    // Builds one frame with random content. Most frames are clean; the rest carry one
    // flaw, or a few at once so that the error priority is exercised, or are cut short.
    // Zero command and board bytes go in before the checksum, so the checksum stays
    // right and only the zero byte is wrong.
    function automatic void build_random_frame(input bit go_long);
        int unsigned          first;
        int unsigned          top;
        int unsigned          len;
        int unsigned          flaw;
        int unsigned          cut;
        logic [DataWidth-1:0] cmd_hi;
        logic [DataWidth-1:0] cmd_lo;
        logic [DataWidth-1:0] brd;
        first  = outgoing.size();
        top    = (tracker.max_length < LEN_MIN) ? LEN_MIN : tracker.max_length;
        len    = go_long ? top : $urandom_range(LEN_MIN, (top < 16) ? top : 16);
        flaw   = $urandom_range(0, 99);
        cmd_hi = (flaw >= 60 && flaw < 64) ? ZERO_BYTE : 8'($urandom_range(1, 255));
        cmd_lo = (flaw >= 64 && flaw < 68) ? ZERO_BYTE : 8'($urandom_range(1, 255));
        brd    = ((flaw >= 68 && flaw < 72) || flaw >= 95 && flaw < 98) ?
                 ZERO_BYTE : 8'($urandom_range(1, 255));
        outgoing.push_back(HEAD0_BYTE);
        outgoing.push_back(HEAD1_BYTE);
        outgoing.push_back(8'(len));
        outgoing.push_back(cmd_hi);
        outgoing.push_back(cmd_lo);
        outgoing.push_back(brd);
        repeat (len - LEN_MIN)
        begin
            outgoing.push_back(8'($urandom_range(0, 255)));
        end
        close_frame(first);
        // Checksum at first+len+3, tail bytes right after it.
        if ((flaw >= 72 && flaw < 78) || (flaw >= 95 && flaw < 98))
            outgoing[first + len + 3] ^= 8'($urandom_range(1, 255));
        if (flaw >= 78 && flaw < 82)
            outgoing[first + len + 4] ^= 8'($urandom_range(1, 255));
        if ((flaw >= 82 && flaw < 86) || (flaw >= 95 && flaw < 98))
            outgoing[first + len + 5] ^= 8'($urandom_range(1, 255));
        if (flaw >= 86 && flaw < 90)
        begin
            outgoing[first + 1] = ($urandom_range(0, 3) == 0) ?
                                  HEAD0_BYTE : HEAD1_BYTE ^ 8'($urandom_range(1, 255));
        end
        if (flaw >= 90 && flaw < 95)
        begin
            if (tracker.max_length < 8'hFF && $urandom_range(0, 1) == 1)
                outgoing[first + 2] = 8'($urandom_range(tracker.max_length + 1, 255));
            else
                outgoing[first + 2] = 8'($urandom_range(0, LEN_MIN - 1));
        end
        if (flaw >= 98)
        begin
            cut = $urandom_range(1, 3);
            repeat (cut)
            begin
                void'(outgoing.pop_back());
            end
        end
    endfunction

    // Random frames until about budget frame bytes are sent. Now and then a burst of
    // stray bytes goes in between, steady stretches come and go, and at times the sender
    // waits for every result. The first frame of each setting uses the greatest length.
    task automatic run_random(input int unsigned budget);
        int unsigned sent;
        int unsigned noise;
        bit          first_frame;
        sent        = 0;
        first_frame = 1'b1;
        while (sent < budget)
        begin
            if ($urandom_range(0, 6) == 0)
                steady = !steady;
            if ($urandom_range(0, 39) == 0)
                settle();
            noise = 0;
            if ($urandom_range(0, 3) == 0)
            begin
                noise = $urandom_range(1, 4);
                repeat (noise)
                begin
                    outgoing.push_back(8'($urandom_range(0, 255)));
                end
            end
            build_random_frame(first_frame || $urandom_range(0, 39) == 0);
            first_frame = 1'b0;
            sent += outgoing.size() - noise;
            send_queued();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        logic [DataWidth-1:0] settings[6];
        tracker = new();
        // The extremes of max_length, zero (every length fails) and a middle value.
        settings[0] = MAX_LENGTH_RESET;
        settings[1] = LEN_MIN;
        settings[2] = 8'hFF;
        settings[3] = ZERO_BYTE;
        settings[4] = 8'($urandom_range(4, 254));
        settings[5] = MAX_LENGTH_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_max_length();
        run_directed();
        settle();
        for (int p = 0; p < 6; p++)
        begin
            // The first setting is the value left by reset.
            if (p != 0)
            begin
                write_max_length(settings[p]);
            end
            run_random(160);
            settle();
        end
        if (tracker.failures == 0 && tracker.drained())
            $display("[xor_checked_frame_parser] OK");
        else
            $display("[xor_checked_frame_parser] ERROR");
        $finish;
    end

endmodule

### xor_checked_frame_parser.f
hdl/xcfp_pkg.sv
hdl/xcfp_regs.sv
hdl/xcfp_parser.sv
hdl/xor_checked_frame_parser.sv
sim/xcfp_check_pkg.sv
sim/xor_checked_frame_parser_test.sv
